@@ hdl/rtp_l16_packetizer_with_level_stats_macros.svh @@
// ----------------------------------------------------------------------------
// RTP L16 packetizer assertion macros
// Shorthand for the concurrent checks used in the packetizer top level.
// ----------------------------------------------------------------------------
`ifndef RTP_L16_PACKETIZER_WITH_LEVEL_STATS_MACROS_SVH
`define RTP_L16_PACKETIZER_WITH_LEVEL_STATS_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RTPL16_ASSERT(lbl, clk, rst_n, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RTPL16_ASSERT_NEXT(lbl, clk, rst_n, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rtpl16_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP L16 packetizer package
// Shared constants, register indexes, word selects and the job record that
// travels from the front end to the word serializer.
// ----------------------------------------------------------------------------
package rtpl16_pkg;

  localparam int MaxPacketSamples = 1024;
  localparam int MinPacketSamples = 80;
  localparam int CntW             = $clog2(MaxPacketSamples + 1);
  localparam int QDepth           = 4;

  localparam logic [7:0]  HdrVersion = 8'h80;
  localparam logic [15:0] ClipLevel  = 16'd32767;
  localparam logic signed [15:0] LowInit  = 16'sh7FFF;
  localparam logic signed [15:0] HighInit = 16'sh8000;

  typedef enum logic [1:0] {
    CfgPayloadType   = 2'd0,
    CfgSourceId      = 2'd1,
    CfgPacketSamples = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    WdVer     = 3'd0,
    WdSeq     = 3'd1,
    WdTsHi    = 3'd2,
    WdTsLo    = 3'd3,
    WdSsrcHi  = 3'd4,
    WdSsrcLo  = 3'd5,
    WdSample  = 3'd6
  } word_sel_e;

  typedef struct packed {
    logic               hdr;
    logic [6:0]         pt;
    logic [15:0]        seq;
    logic [31:0]        ts;
    logic [31:0]        ssrc;
    logic [15:0]        sample;
    logic               last;
    logic [15:0]        peak;
    logic signed [15:0] low;
    logic signed [15:0] high;
    logic [31:0]        clip;
  } job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

@@ hdl/rtp_l16_packetizer_with_level_stats.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP L16 packetizer with level statistics
// Packs signed 16-bit samples into RTP packets of 16-bit words and reports
// per-packet minimum, maximum, peak magnitude and a running clip count.
//
//   Channel   Direction  Handshake                  Payload
//   input     in         push / full                sample_i, final_req_i
//   result    out        empty / pop                word_o, last_word_o, peak_o,
//                                                   lowest_o, highest_o, clip_total_o
//   config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A sample is taken every cycle while the four-entry job queue has room.
// The serializer writes one word per cycle into the output register while
// it is empty or popped, so a sample that opens a packet yields seven words
// (six header words and the sample word) and any other yields one; the
// single output word port thus sets the sustained sample rate.
// Reset is asynchronous; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
`include "rtp_l16_packetizer_with_level_stats_macros.svh"

module rtp_l16_packetizer_with_level_stats (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic signed [15:0]  sample_i,
  input  logic                final_req_i,
  output logic                empty,
  input  logic                pop,
  output logic [15:0]         word_o,
  output logic                last_word_o,
  output logic [15:0]         peak_o,
  output logic signed [15:0]  lowest_o,
  output logic signed [15:0]  highest_o,
  output logic [31:0]         clip_total_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);
  import rtpl16_pkg::*;

  job_t      job, head;
  logic      job_push, head_pop;
  q_stat_t   q_stat;
  logic [16:0] lo_mag, hi_mag, max_mag;

  assign cfg_ready_o = 1'b1;
  assign full        = q_stat.full;

  rtpl16_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_i      (push),
    .sample_i    (sample_i),
    .final_req_i (final_req_i),
    .q_full_i    (q_stat.full),
    .job_push_o  (job_push),
    .job_o       (job)
  );

  rtpl16_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .job_i  (job),
    .pop_i  (head_pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  rtpl16_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (q_stat.valid),
    .head_pop_o   (head_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .word_o       (word_o),
    .last_word_o  (last_word_o),
    .peak_o       (peak_o),
    .lowest_o     (lowest_o),
    .highest_o    (highest_o),
    .clip_total_o (clip_total_o)
  );

  // Peak magnitude implied by the reported extremes.
  always_comb begin
    lo_mag  = lowest_o[15]  ? 17'h1_0000 - {1'b0, lowest_o}  : {1'b0, lowest_o};
    hi_mag  = highest_o[15] ? 17'h1_0000 - {1'b0, highest_o} : {1'b0, highest_o};
    max_mag = (lo_mag > hi_mag) ? lo_mag : hi_mag;
  end

  `RTPL16_ASSERT(a_stats_zero_mid, clk_i, rst_ni, !empty && !last_word_o, (peak_o == '0) && (lowest_o == '0) && (highest_o == '0), "statistics not zero on a word that does not close a packet")
  `RTPL16_ASSERT(a_low_le_high, clk_i, rst_ni, !empty && last_word_o, lowest_o <= highest_o, "packet minimum above packet maximum")
  `RTPL16_ASSERT(a_peak_match, clk_i, rst_ni, !empty && last_word_o, peak_o == max_mag[15:0], "peak disagrees with packet extremes")
  `RTPL16_ASSERT_NEXT(a_no_early_word, clk_i, rst_ni, empty && !q_stat.valid, empty, "result appeared without a queued job")

endmodule

@@ hdl/rtpl16_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP L16 front end
// Holds the configuration and the stream state, takes one sample per cycle
// while the queue has room, updates level statistics, builds a job per sample.
// ----------------------------------------------------------------------------
module rtpl16_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 push_i,
  input  logic signed [15:0]   sample_i,
  input  logic                 final_req_i,
  input  logic                 q_full_i,
  output logic                 job_push_o,
  output rtpl16_pkg::job_t     job_o
);
  import rtpl16_pkg::*;

  logic [6:0]         pt_q;
  logic [31:0]        ssrc_q;
  logic [10:0]        len_cfg_q;
  logic [15:0]        seq_q, seq_d;
  logic [31:0]        ts_q, ts_d;
  logic [31:0]        clip_q, clip_d;
  logic               open_q, open_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic signed [15:0] low_q, low_d;
  logic signed [15:0] high_q, high_d;
  logic [15:0]        peak_q, peak_d;

  logic               accept;
  logic [15:0]        mag;
  logic signed [15:0] low_new, high_new;
  logic [15:0]        peak_new;
  logic [31:0]        clip_new;
  logic [CntW-1:0]    cnt_new;
  logic [CntW-1:0]    eff_len;
  logic               close;

  assign accept = push_i && !q_full_i;

  // Packet length register clamped into the supported range.
  always_comb begin
    if (int'(len_cfg_q) > MaxPacketSamples) begin
      eff_len = CntW'(MaxPacketSamples);
    end else if (int'(len_cfg_q) < MinPacketSamples) begin
      eff_len = CntW'(MinPacketSamples);
    end else begin
      eff_len = CntW'(len_cfg_q);
    end
  end

  always_comb begin
    mag      = sample_i[15] ? 16'(-sample_i) : 16'(sample_i);
    low_new  = (sample_i < low_q)  ? sample_i : low_q;
    high_new = (sample_i > high_q) ? sample_i : high_q;
    peak_new = (mag > peak_q) ? mag : peak_q;
    clip_new = (mag >= ClipLevel) ? clip_q + 32'd1 : clip_q;
    cnt_new  = open_q ? cnt_q + CntW'(1) : CntW'(1);
    close    = final_req_i || (cnt_new >= eff_len);
  end

  always_comb begin
    seq_d  = seq_q;
    ts_d   = ts_q;
    clip_d = clip_q;
    open_d = open_q;
    cnt_d  = cnt_q;
    low_d  = low_q;
    high_d = high_q;
    peak_d = peak_q;
    if (accept) begin
      clip_d = clip_new;
      if (close) begin
        seq_d  = seq_q + 16'd1;
        ts_d   = ts_q + 32'(cnt_new);
        open_d = 1'b0;
        cnt_d  = '0;
        low_d  = LowInit;
        high_d = HighInit;
        peak_d = '0;
      end else begin
        open_d = 1'b1;
        cnt_d  = cnt_new;
        low_d  = low_new;
        high_d = high_new;
        peak_d = peak_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_q      <= 7'd96;
      ssrc_q    <= '0;
      len_cfg_q <= 11'd320;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgPayloadType:   pt_q      <= cfg_data_i[6:0];
        CfgSourceId:      ssrc_q    <= cfg_data_i;
        CfgPacketSamples: len_cfg_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= '0;
      ts_q   <= '0;
      clip_q <= '0;
      open_q <= 1'b0;
      cnt_q  <= '0;
      low_q  <= LowInit;
      high_q <= HighInit;
      peak_q <= '0;
    end else begin
      seq_q  <= seq_d;
      ts_q   <= ts_d;
      clip_q <= clip_d;
      open_q <= open_d;
      cnt_q  <= cnt_d;
      low_q  <= low_d;
      high_q <= high_d;
      peak_q <= peak_d;
    end
  end

  always_comb begin
    job_o.hdr    = !open_q;
    job_o.pt     = pt_q;
    job_o.seq    = seq_q;
    job_o.ts     = ts_q;
    job_o.ssrc   = ssrc_q;
    job_o.sample = sample_i;
    job_o.last   = close;
    job_o.peak   = peak_new;
    job_o.low    = low_new;
    job_o.high   = high_new;
    job_o.clip   = clip_new;
  end

  assign job_push_o = accept;

endmodule

@@ hdl/rtpl16_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP L16 job queue
// Short register queue that decouples the front end from the serializer.
// ----------------------------------------------------------------------------
module rtpl16_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rtpl16_pkg::job_t      job_i,
  input  logic                  pop_i,
  output rtpl16_pkg::job_t      head_o,
  output rtpl16_pkg::q_stat_t   stat_o
);
  import rtpl16_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int LvlW = $clog2(QDepth + 1);

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (lvl_q == LvlW'(QDepth));
  assign stat_o.valid = (lvl_q != '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && stat_o.valid;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    lvl_d    = lvl_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      lvl_d = lvl_q + LvlW'(1);
    end else if (do_pop && !do_push) begin
      lvl_d = lvl_q - LvlW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      lvl_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      lvl_q    <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

@@ hdl/rtpl16_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTP L16 word serializer
// Turns each job into its header words and sample word, one word per cycle,
// into an output register that the consumer drains, while it has room.
// ----------------------------------------------------------------------------
module rtpl16_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rtpl16_pkg::job_t     head_i,
  input  logic                 head_valid_i,
  output logic                 head_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [15:0]          word_o,
  output logic                 last_word_o,
  output logic [15:0]          peak_o,
  output logic signed [15:0]   lowest_o,
  output logic signed [15:0]   highest_o,
  output logic [31:0]          clip_total_o
);
  import rtpl16_pkg::*;

  word_sel_e          phase_q, phase_d, sel, sel_next;
  logic               valid_q;
  logic               load;
  logic [15:0]        word_q, word_d;
  logic               last_q;
  logic [15:0]        peak_q;
  logic signed [15:0] low_q, high_q;
  logic [31:0]        clip_q;
  logic               is_sample;

  assign load      = head_valid_i && (!valid_q || pop_i);
  assign sel       = head_i.hdr ? phase_q : WdSample;
  assign is_sample = (sel == WdSample);
  assign head_pop_o = load && is_sample;

  always_comb begin
    unique case (sel)
      WdVer:    sel_next = WdSeq;
      WdSeq:    sel_next = WdTsHi;
      WdTsHi:   sel_next = WdTsLo;
      WdTsLo:   sel_next = WdSsrcHi;
      WdSsrcHi: sel_next = WdSsrcLo;
      WdSsrcLo: sel_next = WdSample;
      default:  sel_next = WdVer;
    endcase
  end

  always_comb begin
    unique case (sel)
      WdVer:    word_d = {HdrVersion, 1'b0, head_i.pt};
      WdSeq:    word_d = head_i.seq;
      WdTsHi:   word_d = head_i.ts[31:16];
      WdTsLo:   word_d = head_i.ts[15:0];
      WdSsrcHi: word_d = head_i.ssrc[31:16];
      WdSsrcLo: word_d = head_i.ssrc[15:0];
      default:  word_d = head_i.sample;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    if (load) begin
      phase_d = sel_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= WdVer;
      valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (pop_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Statistics show only on the closing word; every other word carries zero.
  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
      last_q <= is_sample && head_i.last;
      peak_q <= (is_sample && head_i.last) ? head_i.peak : '0;
      low_q  <= (is_sample && head_i.last) ? head_i.low  : '0;
      high_q <= (is_sample && head_i.last) ? head_i.high : '0;
      clip_q <= head_i.clip;
    end
  end

  assign empty_o      = !valid_q;
  assign word_o       = word_q;
  assign last_word_o  = last_q;
  assign peak_o       = peak_q;
  assign lowest_o     = low_q;
  assign highest_o    = high_q;
  assign clip_total_o = clip_q;

endmodule
